>>> src/tsf_pkg.sv
// Package for the tuple selection filter: row and slot widths, register
// indexes and the column lookup used by the filter datapath.
// No dependencies.
`default_nettype none

package tsf_pkg;

  localparam int ROW_FIELDS  = 8;
  localparam int CONST_SLOTS = 4;
  localparam int PAIR_SLOTS  = 4;
  localparam int MAX_FIELDS  = 8;
  localparam int MAX_SLOTS   = 4;
  localparam int DATA_W      = 64;
  localparam int POS_W       = 3;
  localparam int CSLOT_W     = 4;
  localparam int PSLOT_W     = 7;
  localparam int CSLOTS_W    = CSLOT_W * MAX_SLOTS;
  localparam int PSLOTS_W    = PSLOT_W * MAX_SLOTS;
  localparam int ADDR_W      = 6;
  localparam int IDX_W       = 3;
  localparam int BYTE_OFS_W  = ADDR_W - IDX_W;

  typedef logic [MAX_FIELDS-1:0][DATA_W-1:0] row_t;

  typedef enum logic [IDX_W-1:0] {
    REG_CONST_SLOTS   = 3'd0,
    REG_CONST_VALUE_0 = 3'd1,
    REG_CONST_VALUE_1 = 3'd2,
    REG_CONST_VALUE_2 = 3'd3,
    REG_CONST_VALUE_3 = 3'd4,
    REG_PAIR_SLOTS    = 3'd5
  } reg_idx_t;

  // A position past the end of the row reads as zero.
  function automatic logic [DATA_W-1:0] col_at(input row_t row, input logic [POS_W-1:0] pos);
    logic [DATA_W-1:0] val;
    val = '0;
    if (int'(pos) < ROW_FIELDS) begin
      val = row[pos];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

>>> src/tuple_selection_filter_unit.sv
// Top level of the tuple selection filter: APB register bank, row input
// register, compare logic and result register.
// Depends on tsf_pkg.
// A passing row is held in the input register and then moves on to the result register.
// Throughput: one row per cycle; the compare logic sits between the input and
// result registers, and a stalled result holds back a passing row but lets a failing row drain.
// Reset clears both pipeline valid flags and all filter registers, so after
// reset every row passes.
`default_nettype none

module tuple_selection_filter_unit
  import tsf_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [DATA_W-1:0]  field_0,
  input  wire  [DATA_W-1:0]  field_1,
  input  wire  [DATA_W-1:0]  field_2,
  input  wire  [DATA_W-1:0]  field_3,
  input  wire  [DATA_W-1:0]  field_4,
  input  wire  [DATA_W-1:0]  field_5,
  input  wire  [DATA_W-1:0]  field_6,
  input  wire  [DATA_W-1:0]  field_7,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [DATA_W-1:0]  out_field_0,
  output logic [DATA_W-1:0]  out_field_1,
  output logic [DATA_W-1:0]  out_field_2,
  output logic [DATA_W-1:0]  out_field_3,
  output logic [DATA_W-1:0]  out_field_4,
  output logic [DATA_W-1:0]  out_field_5,
  output logic [DATA_W-1:0]  out_field_6,
  output logic [DATA_W-1:0]  out_field_7,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [ADDR_W-1:0]  paddr,
  input  wire  [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [CSLOTS_W-1:0]             const_slots;
  logic [MAX_SLOTS-1:0][DATA_W-1:0] const_value;
  logic [PSLOTS_W-1:0]             pair_slots;

  logic        cfg_wr;
  logic [IDX_W-1:0] cfg_idx;

  row_t in_row;
  row_t s1_row;
  logic s1_valid;
  logic s1_pass;
  logic s1_move;
  row_t out_row;
  logic out_ready;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:BYTE_OFS_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      const_slots <= '0;
      const_value <= '0;
      pair_slots  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CONST_SLOTS:   const_slots    <= pwdata[CSLOTS_W-1:0];
        REG_CONST_VALUE_0: const_value[0] <= pwdata;
        REG_CONST_VALUE_1: const_value[1] <= pwdata;
        REG_CONST_VALUE_2: const_value[2] <= pwdata;
        REG_CONST_VALUE_3: const_value[3] <= pwdata;
        REG_PAIR_SLOTS:    pair_slots     <= pwdata[PSLOTS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CONST_SLOTS:   prdata = DATA_W'(const_slots);
      REG_CONST_VALUE_0: prdata = const_value[0];
      REG_CONST_VALUE_1: prdata = const_value[1];
      REG_CONST_VALUE_2: prdata = const_value[2];
      REG_CONST_VALUE_3: prdata = const_value[3];
      REG_PAIR_SLOTS:    prdata = DATA_W'(pair_slots);
      default:           prdata = '0;
    endcase
  end

  assign in_row[0] = field_0;
  assign in_row[1] = field_1;
  assign in_row[2] = field_2;
  assign in_row[3] = field_3;
  assign in_row[4] = field_4;
  assign in_row[5] = field_5;
  assign in_row[6] = field_6;
  assign in_row[7] = field_7;

  // A row fails if any enabled slot within the configured slot counts misses.
  always_comb begin
    logic [CSLOT_W-1:0] cs;
    logic [PSLOT_W-1:0] ps;
    s1_pass = 1'b1;
    for (int s = 0; s < MAX_SLOTS; s++) begin
      cs = const_slots[s*CSLOT_W +: CSLOT_W];
      if (s < CONST_SLOTS && cs[CSLOT_W-1] &&
          col_at(s1_row, cs[POS_W-1:0]) != const_value[s]) begin
        s1_pass = 1'b0;
      end
    end
    for (int s = 0; s < MAX_SLOTS; s++) begin
      ps = pair_slots[s*PSLOT_W +: PSLOT_W];
      if (s < PAIR_SLOTS && ps[PSLOT_W-1] &&
          col_at(s1_row, ps[2*POS_W-1:POS_W]) != col_at(s1_row, ps[POS_W-1:0])) begin
        s1_pass = 1'b0;
      end
    end
  end

  assign out_ready = !out_valid || !out_stall;
  assign s1_move   = !s1_valid || !s1_pass || out_ready;
  assign in_stall  = !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_move) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && in_valid) begin
      s1_row <= in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid && s1_pass;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid && s1_pass) begin
      for (int j = 0; j < MAX_FIELDS; j++) begin
        out_row[j] <= (j < ROW_FIELDS) ? s1_row[j] : '0;
      end
    end
  end

  assign out_field_0 = out_row[0];
  assign out_field_1 = out_row[1];
  assign out_field_2 = out_row[2];
  assign out_field_3 = out_row[3];
  assign out_field_4 = out_row[4];
  assign out_field_5 = out_row[5];
  assign out_field_6 = out_row[6];
  assign out_field_7 = out_row[7];

  a_hold_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_pass && out_valid && out_stall) |-> in_stall)
    else $error("passing row not held while result is stalled");

  a_pass_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_pass && out_ready) |=> (out_valid && out_row[0] == $past(s1_row[0])))
    else $error("passing row not moved to result register");

  a_fail_dropped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !(s1_valid && s1_pass)) |=> !out_valid)
    else $error("result repeated or invented");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!s1_valid && !out_valid))
    else $error("pipeline not cleared by reset");

  a_cfg_slots_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && cfg_idx == REG_CONST_SLOTS) |=> const_slots == $past(pwdata[CSLOTS_W-1:0]))
    else $error("constant slot register write lost");

endmodule

`default_nettype wire

>>> sim/tuple_selection_filter_unit_test.sv
// Self-checking testbench for tuple_selection_filter_unit: streams rows through the
// filter under many register settings and checks each emitted row against a predictor.
// Depends on tsf_pkg and the tuple_selection_filter_unit RTL.
`timescale 1ns / 1ps

module tuple_selection_filter_unit_test;
  import tsf_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int RANDOM_PHASES = 12;
  localparam int ROWS_PER_PHASE = 85;
  localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct {
    row_t cells;
    bit   drain_first;
  } row_request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  row_t drive_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_W-1:0] out_field_0, out_field_1, out_field_2, out_field_3;
  logic [DATA_W-1:0] out_field_4, out_field_5, out_field_6, out_field_7;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  logic [CSLOTS_W-1:0] cfg_const_slots = '0;
  logic [DATA_W-1:0] cfg_const_value [MAX_SLOTS] = '{default: '0};
  logic [PSLOTS_W-1:0] cfg_pair_slots = '0;

  row_request_t pending_requests[$];
  row_t selected_rows[$];
  row_request_t req;
  row_t got_row, want_row;

  int rows_submitted = 0;
  int rows_accepted = 0;
  int rows_kept = 0;
  int settings_count = 1;
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int hold_cycles = 0;
  bit send_quiet = 0;
  bit recv_quiet = 0;
  bit row_taken = 0;
  bit result_taken = 0;

  tuple_selection_filter_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .field_0(drive_row[0]), .field_1(drive_row[1]), .field_2(drive_row[2]),
    .field_3(drive_row[3]), .field_4(drive_row[4]), .field_5(drive_row[5]),
    .field_6(drive_row[6]), .field_7(drive_row[7]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_field_0(out_field_0), .out_field_1(out_field_1), .out_field_2(out_field_2),
    .out_field_3(out_field_3), .out_field_4(out_field_4), .out_field_5(out_field_5),
    .out_field_6(out_field_6), .out_field_7(out_field_7),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] cell_at(input row_t r, input int unsigned pos);
    return (pos < ROW_FIELDS) ? r[pos] : '0;
  endfunction

  function automatic bit row_selected(input row_t r);
    logic [CSLOT_W-1:0] cs;
    logic [PSLOT_W-1:0] ps;
    for (int s = 0; s < CONST_SLOTS; s++) begin
      cs = cfg_const_slots[s*CSLOT_W +: CSLOT_W];
      if (cs[CSLOT_W-1] && cell_at(r, cs[POS_W-1:0]) != cfg_const_value[s]) begin
        return 1'b0;
      end
    end
    for (int s = 0; s < PAIR_SLOTS; s++) begin
      ps = cfg_pair_slots[s*PSLOT_W +: PSLOT_W];
      if (ps[PSLOT_W-1] &&
          cell_at(r, ps[2*POS_W-1:POS_W]) != cell_at(r, ps[POS_W-1:0])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Most rows are bent toward the current filter so that they pass; some of
  // those then get one bit flipped, and the rest stay noise.
  function automatic row_t draw_row();
    row_t r;
    logic [CSLOT_W-1:0] cs;
    logic [PSLOT_W-1:0] ps;
    int unsigned mode, fj, fb;
    mode = $urandom_range(9);
    for (int j = 0; j < MAX_FIELDS; j++) begin
      case ($urandom_range(3))
        0: r[j] = 64'($urandom_range(3));
        1: r[j] = cfg_const_value[$urandom_range(MAX_SLOTS - 1)];
        default: r[j] = {$urandom(), $urandom()};
      endcase
    end
    if (mode >= 3) begin
      for (int k = 0; k < 2; k++) begin
        for (int s = 0; s < CONST_SLOTS; s++) begin
          cs = cfg_const_slots[s*CSLOT_W +: CSLOT_W];
          if (cs[CSLOT_W-1] && cs[POS_W-1:0] < ROW_FIELDS) begin
            r[cs[POS_W-1:0]] = cfg_const_value[s];
          end
        end
        for (int s = 0; s < PAIR_SLOTS; s++) begin
          ps = cfg_pair_slots[s*PSLOT_W +: PSLOT_W];
          if (ps[PSLOT_W-1] && ps[POS_W-1:0] < ROW_FIELDS) begin
            r[ps[POS_W-1:0]] = cell_at(r, ps[2*POS_W-1:POS_W]);
          end
        end
      end
    end
    if (mode >= 8) begin
      fj = $urandom_range(MAX_FIELDS - 1);
      fb = $urandom_range(DATA_W - 1);
      r[fj][fb] = ~r[fj][fb];
    end
    return r;
  endfunction

  task automatic queue_row(input row_t cells, input bit drain_first);
    row_request_t item;
    item.cells = cells;
    item.drain_first = drain_first;
    pending_requests = {pending_requests, item};
    rows_submitted++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, {BYTE_OFS_W{1'b0}}};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_CONST_SLOTS: cfg_const_slots = value[CSLOTS_W-1:0];
      REG_CONST_VALUE_0: cfg_const_value[0] = value;
      REG_CONST_VALUE_1: cfg_const_value[1] = value;
      REG_CONST_VALUE_2: cfg_const_value[2] = value;
      REG_CONST_VALUE_3: cfg_const_value[3] = value;
      REG_PAIR_SLOTS: cfg_pair_slots = value[PSLOTS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (!(rows_accepted == rows_submitted && selected_rows.size() == 0)) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || row_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].drain_first && selected_rows.size() != 0)) begin
        req = pending_requests.pop_front();
        drive_row <= req.cells;
        in_valid <= 1'b1;
        if ($urandom_range(39) == 0) send_quiet = !send_quiet;
        send_gap = send_quiet ? 0 : $urandom_range(13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (result_taken) begin
      if ($urandom_range(39) == 0) recv_quiet = !recv_quiet;
      hold_cycles = recv_quiet ? 0 : $urandom_range(13);
    end
    out_stall <= (hold_cycles != 0);
    if (hold_cycles != 0) hold_cycles--;
  end

  always @(posedge clk) begin
    row_taken = 1'b0;
    result_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        row_taken = 1'b1;
        rows_accepted++;
        if (row_selected(drive_row)) begin
          want_row = '0;
          for (int j = 0; j < ROW_FIELDS; j++) want_row[j] = drive_row[j];
          selected_rows = {selected_rows, want_row};
          rows_kept++;
        end
      end
      if (out_valid && !out_stall) begin
        result_taken = 1'b1;
        got_row = {out_field_7, out_field_6, out_field_5, out_field_4,
                   out_field_3, out_field_2, out_field_1, out_field_0};
        if (selected_rows.size() == 0) begin
          if (mismatches < 10) $display("Unexpected row at %0t: %h", $realtime, got_row);
          mismatches++;
        end else begin
          want_row = selected_rows.pop_front();
          for (int j = 0; j < MAX_FIELDS; j++) begin
            if (got_row[j] !== want_row[j]) begin
              if (mismatches < 10) begin
                $display("Mismatch at %0t on out_field_%0d: expected %h, got %h",
                         $realtime, j, want_row[j], got_row[j]);
              end
              mismatches++;
            end
          end
        end
      end
      idle_cycles = (row_taken || result_taken) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Timeout: nothing moved for %0d cycles.", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    row_t base, r;
    logic [CSLOTS_W-1:0] cs;
    logic [PSLOTS_W-1:0] ps;
    logic [DATA_W-1:0] v;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With every register at reset the filter is empty and every row passes.
    queue_row('0, 1'b0);
    queue_row('1, 1'b0);
    queue_row({MAX_FIELDS{64'hAAAA_AAAA_AAAA_AAAA}}, 1'b0);
    queue_row({MAX_FIELDS{64'h5555_5555_5555_5555}}, 1'b0);

    // Two constant slots on the same column, a pair slot naming one column
    // twice, and disabled slots that carry live positions.
    wait_idle();
    settings_count++;
    write_reg(REG_CONST_SLOTS, 64'({4'b1011, 4'b1011, 4'b1111, 4'b1000}));
    write_reg(REG_CONST_VALUE_0, '1);
    write_reg(REG_CONST_VALUE_1, '0);
    write_reg(REG_CONST_VALUE_2, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_CONST_VALUE_3, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_PAIR_SLOTS, 64'({7'b0000111, 7'b0100110, 7'b1101101, 7'b1001010}));
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, 64'hDEAD_BEEF_0BAD_F00D);
    base = '0;
    base[0] = '1;
    base[1] = 64'h8000_0000_0000_0001;
    base[2] = 64'h8000_0000_0000_0001;
    base[3] = 64'h0123_4567_89AB_CDEF;
    base[4] = 64'h1111_2222_3333_4444;
    base[5] = 64'hFEDC_BA98_7654_3210;
    base[6] = 64'h7FFF_FFFF_FFFF_FFFE;
    queue_row(base, 1'b0);
    r = base; r[0][17] = 1'b0; queue_row(r, 1'b0);
    r = base; r[7] = 64'd1; queue_row(r, 1'b0);
    r = base; r[3] = ~r[3]; queue_row(r, 1'b0);
    r = base; r[2] = r[2] + 1; queue_row(r, 1'b0);
    r = base; r[4] = 64'd9; r[6] = 64'd5; queue_row(r, 1'b0);

    wait_idle();
    settings_count++;
    write_reg(REG_CONST_SLOTS, 64'h7777);
    write_reg(REG_PAIR_SLOTS, '1);
    queue_row({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom(), $urandom()}, 1'b0);
    queue_row('0, 1'b0);

    wait_idle();
    settings_count++;
    write_reg(REG_CONST_SLOTS, '1);
    write_reg(REG_CONST_VALUE_0, '1);
    write_reg(REG_CONST_VALUE_1, '1);
    write_reg(REG_CONST_VALUE_2, '1);
    write_reg(REG_CONST_VALUE_3, '1);
    write_reg(REG_PAIR_SLOTS, '0);
    queue_row('1, 1'b0);
    queue_row('0, 1'b0);
    base = '0;
    base[7] = '1;
    queue_row(base, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      settings_count++;
      cs = CSLOTS_W'($urandom());
      ps = PSLOTS_W'($urandom());
      if (p == 3) cs = '1;
      if (p == 4) ps = '1;
      if (p == 5) begin
        cs = '0;
        ps = '0;
      end
      write_reg(REG_CONST_SLOTS, 64'(cs));
      for (int s = 0; s < MAX_SLOTS; s++) begin
        case ($urandom_range(3))
          0: v = '0;
          1: v = '1;
          default: v = {$urandom(), $urandom()};
        endcase
        if (p == 3) v = 64'h0F0F_0F0F_F0F0_F0F0;
        write_reg(reg_idx_t'(REG_CONST_VALUE_0 + s), v);
      end
      write_reg(REG_PAIR_SLOTS, 64'(ps));
      for (int i = 0; i < ROWS_PER_PHASE; i++) begin
        queue_row(draw_row(), i == ROWS_PER_PHASE / 2);
      end
    end

    wait_idle();
    $display("Sent %0d rows under %0d filter settings; %0d were selected.",
             rows_accepted, settings_count, rows_kept);
    $display("Mismatched or unexpected result fields: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/tsf_pkg.sv
src/tuple_selection_filter_unit.sv
sim/tuple_selection_filter_unit_test.sv
